>>> src/gst_pkg.sv
package gst_pkg;

   localparam int unsigned DEF_MAX_ELEMENTS = 1024;
   localparam int unsigned DEF_TREE_NODES   = 4096;
   localparam int unsigned REQ_IDX_W        = 10;
   localparam int unsigned CFG_W            = 11;
   localparam int unsigned GCD_W            = 32;
   localparam int unsigned LCM_W            = 64;
   localparam int unsigned VALUE_BITS       = 32;
   localparam int unsigned NODE_W           = 1 + LCM_W + GCD_W;

   localparam logic [GCD_W-1:0] VALUE_MASK = GCD_W'((64'd1 << VALUE_BITS) - 64'd1);

   typedef enum logic {
      CMD_UPDATE = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_ERROR = 1'b1
   } status_type;

   typedef struct packed {
      logic             sat;
      logic [LCM_W-1:0] lcm;
      logic [GCD_W-1:0] gcd;
   } node_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLEAR,
      DP_LOAD,
      DP_DESC,
      DP_WR_LEAF,
      DP_UP,
      DP_RD_LCHILD,
      DP_LA_RD_RCHILD,
      DP_LB_RD,
      DP_JOIN_GO,
      DP_WR_JOIN,
      DP_RD_CUR,
      DP_LAB_ACC,
      DP_ACC_TAKE,
      DP_GO_LEFT,
      DP_GO_RIGHT,
      DP_PUSH_GO_LEFT,
      DP_POP,
      DP_RSP_QUERY,
      DP_RSP_UPDATE,
      DP_RSP_ERROR
   } dp_op_type;

   typedef struct packed {
      logic clear_last;
      logic invalid;
      logic is_update;
      logic is_leaf;
      logic at_root;
      logic covered;
      logic go_right;
      logic go_left;
      logic stack_empty;
      logic join_done;
   } ctrl_status_type;

endpackage

>>> src/gst_ram.sv
module gst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gst_join.sv
module gst_join (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  gst_pkg::node_type a,
   input  gst_pkg::node_type b,
   output logic              done,
   output gst_pkg::node_type r
);

   typedef enum logic [2:0] {
      J_IDLE,
      J_GCD_G,
      J_GCD_L,
      J_DIV,
      J_MUL
   } join_state_type;

   localparam int unsigned L_W = gst_pkg::LCM_W;

   join_state_type    state_ff;
   logic              done_ff;
   gst_pkg::node_type a_ff;
   gst_pkg::node_type b_ff;
   gst_pkg::node_type r_ff;
   logic [L_W-1:0]    u_ff;
   logic [L_W-1:0]    v_ff;
   logic [5:0]        k_ff;
   logic [L_W-1:0]    div_ff;
   logic [L_W-1:0]    rem_ff;
   logic [L_W-1:0]    quo_ff;
   logic [5:0]        cnt_ff;
   logic [2*L_W-1:0]  prod_ff;

   logic              gcd_fin;
   logic [L_W-1:0]    gcd_res;
   logic [L_W-1:0]    u_step;
   logic [L_W-1:0]    v_step;
   logic [5:0]        k_step;
   logic [L_W:0]      rem_sh;
   logic              div_ge;
   logic [L_W:0]      mul_sum;
   logic [2*L_W-1:0]  prod_next;

   always_comb begin
      gcd_fin = (u_ff == '0) || (v_ff == '0);
      gcd_res = (u_ff | v_ff) << k_ff;
      u_step  = u_ff;
      v_step  = v_ff;
      k_step  = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_step = u_ff >> 1;
         v_step = v_ff >> 1;
         k_step = k_ff + 6'd1;
      end else if (!u_ff[0]) begin
         u_step = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_step = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_step = u_ff - v_ff;
      end else begin
         v_step = v_ff - u_ff;
      end
      rem_sh    = {rem_ff, quo_ff[L_W-1]};
      div_ge    = rem_sh >= {1'b0, div_ff};
      mul_sum   = {1'b0, prod_ff[2*L_W-1:L_W]} + (quo_ff[0] ? {1'b0, b_ff.lcm} : '0);
      prod_next = {mul_sum, prod_ff[L_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= J_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            J_IDLE: begin
               if (go) begin
                  a_ff     <= a;
                  b_ff     <= b;
                  u_ff     <= L_W'(a.gcd);
                  v_ff     <= L_W'(b.gcd);
                  k_ff     <= '0;
                  state_ff <= J_GCD_G;
               end
            end
            J_GCD_G: begin
               if (gcd_fin) begin
                  r_ff.gcd <= gcd_res[gst_pkg::GCD_W-1:0];
                  if (a_ff.lcm == '0 || b_ff.lcm == '0) begin
                     r_ff.lcm <= '0;
                     r_ff.sat <= 1'b0;
                     done_ff  <= 1'b1;
                     state_ff <= J_IDLE;
                  end else if (a_ff.sat || b_ff.sat) begin
                     r_ff.lcm <= '1;
                     r_ff.sat <= 1'b1;
                     done_ff  <= 1'b1;
                     state_ff <= J_IDLE;
                  end else begin
                     u_ff     <= a_ff.lcm;
                     v_ff     <= b_ff.lcm;
                     k_ff     <= '0;
                     state_ff <= J_GCD_L;
                  end
               end else begin
                  u_ff <= u_step;
                  v_ff <= v_step;
                  k_ff <= k_step;
               end
            end
            J_GCD_L: begin
               if (gcd_fin) begin
                  div_ff   <= gcd_res;
                  rem_ff   <= '0;
                  quo_ff   <= a_ff.lcm;
                  cnt_ff   <= '0;
                  state_ff <= J_DIV;
               end else begin
                  u_ff <= u_step;
                  v_ff <= v_step;
                  k_ff <= k_step;
               end
            end
            J_DIV: begin
               if (div_ge) begin
                  rem_ff <= L_W'(rem_sh - {1'b0, div_ff});
                  quo_ff <= {quo_ff[L_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[L_W-1:0];
                  quo_ff <= {quo_ff[L_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  prod_ff  <= '0;
                  state_ff <= J_MUL;
               end
            end
            J_MUL: begin
               prod_ff <= prod_next;
               quo_ff  <= quo_ff >> 1;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  if (prod_next[2*L_W-1:L_W] != '0) begin
                     r_ff.lcm <= '1;
                     r_ff.sat <= 1'b1;
                  end else begin
                     r_ff.lcm <= prod_next[L_W-1:0];
                     r_ff.sat <= 1'b0;
                  end
                  done_ff  <= 1'b1;
                  state_ff <= J_IDLE;
               end
            end
            default: begin
               state_ff <= J_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign r    = r_ff;

endmodule

>>> src/gst_datapath.sv
module gst_datapath #(
   parameter int unsigned MAX_ELEMENTS = gst_pkg::DEF_MAX_ELEMENTS,
   parameter int unsigned TREE_NODES   = gst_pkg::DEF_TREE_NODES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gst_pkg::dp_op_type             op,
   output gst_pkg::ctrl_status_type       status,
   input  logic                           req_cmd,
   input  logic [gst_pkg::REQ_IDX_W-1:0]  req_position,
   input  logic [gst_pkg::GCD_W-1:0]      req_value,
   input  logic [gst_pkg::REQ_IDX_W-1:0]  req_range_start,
   input  logic [gst_pkg::REQ_IDX_W-1:0]  req_range_end,
   input  logic                           csr_valid,
   input  logic [gst_pkg::CFG_W-1:0]      csr_element_count,
   output logic                           rsp_valid,
   output logic [gst_pkg::GCD_W-1:0]      rsp_range_gcd,
   output logic [gst_pkg::LCM_W-1:0]      rsp_range_lcm,
   output logic                           rsp_lcm_saturated,
   output logic                           rsp_status
);

   localparam int unsigned ID_W  = $clog2(TREE_NODES);
   localparam int unsigned ID1_W = ID_W + 1;
   localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
   localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned STK_D = IDX_W + 1;
   localparam int unsigned STK_W = $clog2(STK_D);
   localparam int unsigned SP_W  = $clog2(STK_D + 1);
   localparam int unsigned CMP_W = (CNT_W > gst_pkg::CFG_W) ? CNT_W : gst_pkg::CFG_W;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } frame_type;

   logic [gst_pkg::REQ_IDX_W-1:0] pos_ff;
   logic [gst_pkg::REQ_IDX_W-1:0] s_ff;
   logic [gst_pkg::REQ_IDX_W-1:0] e_ff;
   logic [gst_pkg::GCD_W-1:0]     val_ff;
   gst_pkg::cmd_type              cmd_ff;
   logic [ID_W-1:0]               id_ff;
   logic [IDX_W-1:0]              lo_ff;
   logic [IDX_W-1:0]              hi_ff;
   logic [SP_W-1:0]               sp_ff;
   frame_type                     stack_ff [STK_D];
   gst_pkg::node_type             acc_ff;
   gst_pkg::node_type             opa_ff;
   gst_pkg::node_type             opb_ff;
   logic [ID_W-1:0]               clr_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          rsp_valid_ff;
   logic [gst_pkg::GCD_W-1:0]     rsp_gcd_ff;
   logic [gst_pkg::LCM_W-1:0]     rsp_lcm_ff;
   logic                          rsp_sat_ff;
   gst_pkg::status_type           rsp_status_ff;

   logic [CMP_W-1:0]              cfg_x;
   logic [CMP_W-1:0]              cnt_x;
   logic [CMP_W-1:0]              lo_x;
   logic [CMP_W-1:0]              hi_x;
   logic [CMP_W-1:0]              mid_x;
   logic [CMP_W-1:0]              pos_x;
   logic [CMP_W-1:0]              s_x;
   logic [CMP_W-1:0]              e_x;
   logic [IDX_W:0]                mid_sum;
   logic [IDX_W-1:0]              mid;
   logic [ID_W-1:0]               lchild;
   logic [ID_W-1:0]               rchild;
   logic [ID_W-1:0]               parent;
   logic [SP_W-1:0]               sp_dec;
   frame_type                     top_frame;

   logic                          wr_en;
   logic [ID_W-1:0]               wr_addr;
   gst_pkg::node_type             wr_node;
   logic [ID_W-1:0]               rd_addr;
   logic [gst_pkg::NODE_W-1:0]    rd_data;
   gst_pkg::node_type             rd_node;
   gst_pkg::node_type             leaf_node;
   logic                          join_done;
   gst_pkg::node_type             join_r;

   always_comb begin
      cfg_x = CMP_W'(csr_element_count);
      if (cfg_x == '0) begin
         count_in = CNT_W'(1);
      end else if (cfg_x > CMP_W'(MAX_ELEMENTS)) begin
         count_in = CNT_W'(MAX_ELEMENTS);
      end else begin
         count_in = CNT_W'(cfg_x);
      end
   end

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[IDX_W:1];
   assign cnt_x     = CMP_W'(count_ff);
   assign lo_x      = CMP_W'(lo_ff);
   assign hi_x      = CMP_W'(hi_ff);
   assign mid_x     = CMP_W'(mid);
   assign pos_x     = CMP_W'(pos_ff);
   assign s_x       = CMP_W'(s_ff);
   assign e_x       = CMP_W'(e_ff);
   assign lchild    = ID_W'({id_ff, 1'b0} + ID1_W'(1));
   assign rchild    = ID_W'({id_ff, 1'b0} + ID1_W'(2));
   assign parent    = ID_W'((id_ff - ID_W'(1)) >> 1);
   assign sp_dec    = sp_ff - SP_W'(1);
   assign top_frame = stack_ff[sp_dec[STK_W-1:0]];
   assign rd_node   = gst_pkg::node_type'(rd_data);

   always_comb begin
      leaf_node.sat = 1'b0;
      leaf_node.gcd = val_ff & gst_pkg::VALUE_MASK;
      leaf_node.lcm = gst_pkg::LCM_W'(val_ff & gst_pkg::VALUE_MASK);
   end

   always_comb begin
      status.clear_last  = clr_ff == ID_W'(TREE_NODES - 1);
      status.is_update   = cmd_ff == gst_pkg::CMD_UPDATE;
      status.invalid     = (cmd_ff == gst_pkg::CMD_UPDATE) ? (pos_x >= cnt_x)
                                                          : ((s_x > e_x) || (e_x >= cnt_x));
      status.is_leaf     = lo_ff == hi_ff;
      status.at_root     = id_ff == '0;
      status.covered     = (cmd_ff == gst_pkg::CMD_UPDATE) ? (mid_x < pos_x)
                                                          : ((s_x <= lo_x) && (hi_x <= e_x));
      status.go_right    = mid_x < s_x;
      status.go_left     = mid_x >= e_x;
      status.stack_empty = sp_ff == '0;
      status.join_done   = join_done;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = id_ff;
      wr_node = leaf_node;
      rd_addr = id_ff;
      case (op)
         gst_pkg::DP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_node = '0;
         end
         gst_pkg::DP_WR_LEAF: begin
            wr_en = 1'b1;
         end
         gst_pkg::DP_WR_JOIN: begin
            wr_en   = 1'b1;
            wr_node = join_r;
         end
         gst_pkg::DP_RD_LCHILD: begin
            rd_addr = lchild;
         end
         gst_pkg::DP_LA_RD_RCHILD: begin
            rd_addr = rchild;
         end
         default: begin
            rd_addr = id_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         sp_ff        <= '0;
         count_ff     <= CNT_W'(MAX_ELEMENTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            count_ff <= count_in;
         end
         case (op)
            gst_pkg::DP_CLEAR: begin
               clr_ff <= clr_ff + ID_W'(1);
            end
            gst_pkg::DP_LOAD: begin
               cmd_ff     <= gst_pkg::cmd_type'(req_cmd);
               pos_ff     <= req_position;
               val_ff     <= req_value;
               s_ff       <= req_range_start;
               e_ff       <= req_range_end;
               id_ff      <= '0;
               lo_ff      <= '0;
               hi_ff      <= IDX_W'(count_ff - CNT_W'(1));
               sp_ff      <= '0;
               acc_ff.gcd <= '0;
               acc_ff.lcm <= gst_pkg::LCM_W'(1);
               acc_ff.sat <= 1'b0;
            end
            gst_pkg::DP_DESC: begin
               if (mid_x < pos_x) begin
                  id_ff <= rchild;
                  lo_ff <= mid + IDX_W'(1);
               end else begin
                  id_ff <= lchild;
                  hi_ff <= mid;
               end
            end
            gst_pkg::DP_UP: begin
               id_ff <= parent;
            end
            gst_pkg::DP_LA_RD_RCHILD: begin
               opa_ff <= rd_node;
            end
            gst_pkg::DP_LB_RD: begin
               opb_ff <= rd_node;
            end
            gst_pkg::DP_LAB_ACC: begin
               opa_ff <= acc_ff;
               opb_ff <= rd_node;
            end
            gst_pkg::DP_ACC_TAKE: begin
               acc_ff <= join_r;
            end
            gst_pkg::DP_GO_LEFT: begin
               id_ff <= lchild;
               hi_ff <= mid;
            end
            gst_pkg::DP_GO_RIGHT: begin
               id_ff <= rchild;
               lo_ff <= mid + IDX_W'(1);
            end
            gst_pkg::DP_PUSH_GO_LEFT: begin
               stack_ff[sp_ff[STK_W-1:0]] <= '{id: rchild, lo: mid + IDX_W'(1), hi: hi_ff};
               sp_ff <= sp_ff + SP_W'(1);
               id_ff <= lchild;
               hi_ff <= mid;
            end
            gst_pkg::DP_POP: begin
               id_ff <= top_frame.id;
               lo_ff <= top_frame.lo;
               hi_ff <= top_frame.hi;
               sp_ff <= sp_dec;
            end
            gst_pkg::DP_RSP_QUERY: begin
               rsp_valid_ff  <= 1'b1;
               rsp_gcd_ff    <= acc_ff.gcd;
               rsp_lcm_ff    <= acc_ff.lcm;
               rsp_sat_ff    <= acc_ff.sat;
               rsp_status_ff <= gst_pkg::STATUS_OK;
            end
            gst_pkg::DP_RSP_UPDATE: begin
               rsp_valid_ff  <= 1'b1;
               rsp_gcd_ff    <= '0;
               rsp_lcm_ff    <= '0;
               rsp_sat_ff    <= 1'b0;
               rsp_status_ff <= gst_pkg::STATUS_OK;
            end
            gst_pkg::DP_RSP_ERROR: begin
               rsp_valid_ff  <= 1'b1;
               rsp_gcd_ff    <= '0;
               rsp_lcm_ff    <= '0;
               rsp_sat_ff    <= 1'b0;
               rsp_status_ff <= gst_pkg::STATUS_ERROR;
            end
            default: begin
               sp_ff <= sp_ff;
            end
         endcase
      end
   end

   gst_ram #(
      .WIDTH (gst_pkg::NODE_W),
      .DEPTH (TREE_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_node),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gst_join u_join (
      .clock (clock),
      .reset (reset),
      .go    (op == gst_pkg::DP_JOIN_GO),
      .a     (opa_ff),
      .b     (opb_ff),
      .done  (join_done),
      .r     (join_r)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_gcd     = rsp_gcd_ff;
   assign rsp_range_lcm     = rsp_lcm_ff;
   assign rsp_lcm_saturated = rsp_sat_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> src/gst_ctrl.sv
module gst_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  gst_pkg::ctrl_status_type status,
   output logic                     busy,
   output gst_pkg::dp_op_type       op
);

   typedef enum logic [3:0] {
      C_CLEAR,
      C_IDLE,
      C_CHECK,
      C_U_DESC,
      C_U_ASC,
      C_U_RDL,
      C_U_LA,
      C_U_LB,
      C_U_GO,
      C_U_WAIT,
      C_Q_VISIT,
      C_Q_LAB,
      C_Q_GO,
      C_Q_WAIT,
      C_Q_NEXT
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           busy_ff;

   always_comb begin
      state_in = state_ff;
      op       = gst_pkg::DP_NOP;
      case (state_ff)
         C_CLEAR: begin
            op = gst_pkg::DP_CLEAR;
            if (status.clear_last) begin
               state_in = C_IDLE;
            end
         end
         C_IDLE: begin
            if (start) begin
               op       = gst_pkg::DP_LOAD;
               state_in = C_CHECK;
            end
         end
         C_CHECK: begin
            if (status.invalid) begin
               op       = gst_pkg::DP_RSP_ERROR;
               state_in = C_IDLE;
            end else if (status.is_update) begin
               state_in = C_U_DESC;
            end else begin
               state_in = C_Q_VISIT;
            end
         end
         C_U_DESC: begin
            if (status.is_leaf) begin
               op       = gst_pkg::DP_WR_LEAF;
               state_in = C_U_ASC;
            end else begin
               op = gst_pkg::DP_DESC;
            end
         end
         C_U_ASC: begin
            if (status.at_root) begin
               op       = gst_pkg::DP_RSP_UPDATE;
               state_in = C_IDLE;
            end else begin
               op       = gst_pkg::DP_UP;
               state_in = C_U_RDL;
            end
         end
         C_U_RDL: begin
            op       = gst_pkg::DP_RD_LCHILD;
            state_in = C_U_LA;
         end
         C_U_LA: begin
            op       = gst_pkg::DP_LA_RD_RCHILD;
            state_in = C_U_LB;
         end
         C_U_LB: begin
            op       = gst_pkg::DP_LB_RD;
            state_in = C_U_GO;
         end
         C_U_GO: begin
            op       = gst_pkg::DP_JOIN_GO;
            state_in = C_U_WAIT;
         end
         C_U_WAIT: begin
            if (status.join_done) begin
               op       = gst_pkg::DP_WR_JOIN;
               state_in = C_U_ASC;
            end
         end
         C_Q_VISIT: begin
            if (status.covered) begin
               op       = gst_pkg::DP_RD_CUR;
               state_in = C_Q_LAB;
            end else if (status.go_right) begin
               op = gst_pkg::DP_GO_RIGHT;
            end else if (status.go_left) begin
               op = gst_pkg::DP_GO_LEFT;
            end else begin
               op = gst_pkg::DP_PUSH_GO_LEFT;
            end
         end
         C_Q_LAB: begin
            op       = gst_pkg::DP_LAB_ACC;
            state_in = C_Q_GO;
         end
         C_Q_GO: begin
            op       = gst_pkg::DP_JOIN_GO;
            state_in = C_Q_WAIT;
         end
         C_Q_WAIT: begin
            if (status.join_done) begin
               op       = gst_pkg::DP_ACC_TAKE;
               state_in = C_Q_NEXT;
            end
         end
         C_Q_NEXT: begin
            if (status.stack_empty) begin
               op       = gst_pkg::DP_RSP_QUERY;
               state_in = C_IDLE;
            end else begin
               op       = gst_pkg::DP_POP;
               state_in = C_Q_VISIT;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= state_in != C_IDLE;
      end
   end

   assign busy = busy_ff;

endmodule

>>> src/gcd_lcm_segment_tree.sv
// Channel  | Ports                                   | Handshake
// request  | req_cmd/position/value/range_start/end  | taken when start && !busy
// response | rsp_range_gcd/lcm, lcm_saturated, status| rsp_valid, one cycle, no stall
// csr      | csr_element_count                       | csr_valid && csr_ready
//
// One word in flight. An update walks down to the leaf, then does one node join per
// level on the way up; a query joins each covering node into an accumulator.
// A join runs a binary GCD on the 32-bit GCDs, then one on the 64-bit LCMs, a bit-serial
// divide and a bit-serial multiply; a zero or saturated LCM skips all but the first GCD.
// After reset the node memory is swept to zero with busy high.
// The response cannot be held off; csr writes are taken at any time.
module gcd_lcm_segment_tree #(
   parameter int unsigned MAX_ELEMENTS = gst_pkg::DEF_MAX_ELEMENTS,
   parameter int unsigned TREE_NODES   = gst_pkg::DEF_TREE_NODES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [gst_pkg::REQ_IDX_W-1:0] req_position,
   input  logic [gst_pkg::GCD_W-1:0]     req_value,
   input  logic [gst_pkg::REQ_IDX_W-1:0] req_range_start,
   input  logic [gst_pkg::REQ_IDX_W-1:0] req_range_end,
   output logic                          rsp_valid,
   output logic [gst_pkg::GCD_W-1:0]     rsp_range_gcd,
   output logic [gst_pkg::LCM_W-1:0]     rsp_range_lcm,
   output logic                          rsp_lcm_saturated,
   output logic                          rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gst_pkg::CFG_W-1:0]     csr_element_count
);

   gst_pkg::dp_op_type       op;
   gst_pkg::ctrl_status_type status;

   gst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .op     (op)
   );

   gst_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TREE_NODES   (TREE_NODES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_position      (req_position),
      .req_value         (req_value),
      .req_range_start   (req_range_start),
      .req_range_end     (req_range_end),
      .csr_valid         (csr_valid),
      .csr_element_count (csr_element_count),
      .rsp_valid         (rsp_valid),
      .rsp_range_gcd     (rsp_range_gcd),
      .rsp_range_lcm     (rsp_range_lcm),
      .rsp_lcm_saturated (rsp_lcm_saturated),
      .rsp_status        (rsp_status)
   );

   assign csr_ready = 1'b1;

endmodule

>>> dv/gcd_lcm_segment_tree_test.sv
module gcd_lcm_segment_tree_test;

   typedef enum logic [1:0] {
      OP_WORD,
      OP_CSR,
      OP_DRAIN
   } op_kind_type;

   typedef struct {
      op_kind_type                          kind;
      gst_pkg::cmd_type                     cmd;
      logic [gst_pkg::REQ_IDX_W-1:0]        position;
      logic [gst_pkg::GCD_W-1:0]            value;
      logic [gst_pkg::REQ_IDX_W-1:0]        range_start;
      logic [gst_pkg::REQ_IDX_W-1:0]        range_end;
      logic [gst_pkg::CFG_W-1:0]            count;
      int unsigned                          gap;
   } op_type;

   typedef struct {
      logic [gst_pkg::GCD_W-1:0] gcd;
      logic [gst_pkg::LCM_W-1:0] lcm;
      logic                      sat;
      gst_pkg::status_type       status;
   } answer_type;

   typedef struct {
      logic [63:0] g;
      logic [63:0] l;
      logic        sat;
   } pair_type;

   localparam logic [63:0] ALL_ONES = '1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_cmd = 1'b0;
   logic [gst_pkg::REQ_IDX_W-1:0] req_position = '0;
   logic [gst_pkg::GCD_W-1:0]     req_value = '0;
   logic [gst_pkg::REQ_IDX_W-1:0] req_range_start = '0;
   logic [gst_pkg::REQ_IDX_W-1:0] req_range_end = '0;
   logic                          rsp_valid;
   logic [gst_pkg::GCD_W-1:0]     rsp_range_gcd;
   logic [gst_pkg::LCM_W-1:0]     rsp_range_lcm;
   logic                          rsp_lcm_saturated;
   logic                          rsp_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [gst_pkg::CFG_W-1:0]     csr_element_count = '0;

   logic [gst_pkg::GCD_W-1:0] tree_gcd[gst_pkg::DEF_TREE_NODES];
   logic [gst_pkg::LCM_W-1:0] tree_lcm[gst_pkg::DEF_TREE_NODES];
   logic                      tree_sat[gst_pkg::DEF_TREE_NODES];
   int unsigned               element_count = gst_pkg::DEF_MAX_ELEMENTS;

   op_type      pending_ops[$];
   answer_type  expected_answers[$];
   op_type      cur;
   bit          have_op = 0;
   int unsigned hold_cnt = 0;
   int unsigned errors = 0;
   int unsigned n_query = 0, n_update = 0, n_invalid = 0, n_sat = 0, n_csr = 0;

   gcd_lcm_segment_tree i_dut (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_position, .req_value, .req_range_start, .req_range_end,
      .rsp_valid, .rsp_range_gcd, .rsp_range_lcm, .rsp_lcm_saturated, .rsp_status,
      .csr_valid, .csr_ready, .csr_element_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (a != 0) begin
         t = b % a;
         b = a;
         a = t;
      end
      return b;
   endfunction

   function automatic pair_type combine(pair_type x, pair_type y);
      pair_type    r;
      logic [63:0] q;
      r.g = gcd_of(x.g, y.g);
      r.sat = 1'b0;
      r.l = '0;
      if (x.l == 0 || y.l == 0) begin
         r.l = '0;
      end else if (x.sat || y.sat) begin
         r.l = ALL_ONES;
         r.sat = 1'b1;
      end else begin
         q = x.l / gcd_of(x.l, y.l);
         if (q > ALL_ONES / y.l) begin
            r.l = ALL_ONES;
            r.sat = 1'b1;
         end else begin
            r.l = q * y.l;
         end
      end
      return r;
   endfunction

   function automatic pair_type node_get(int unsigned id);
      pair_type p;
      p = '{64'd0, 64'd0, 1'b0};
      if (id < gst_pkg::DEF_TREE_NODES) begin
         p.g = {32'd0, tree_gcd[id]};
         p.l = tree_lcm[id];
         p.sat = tree_sat[id];
      end
      return p;
   endfunction

   function automatic void node_put(int unsigned id, pair_type p);
      if (id < gst_pkg::DEF_TREE_NODES) begin
         tree_gcd[id] = p.g[31:0];
         tree_lcm[id] = p.l;
         tree_sat[id] = p.sat;
      end
   endfunction

   function automatic void tree_write(int unsigned id, int unsigned lo, int unsigned hi,
                                      int unsigned pos, logic [63:0] v);
      int unsigned mid;
      if (lo == hi) begin
         node_put(id, '{v, v, 1'b0});
         return;
      end
      mid = (lo + hi) / 2;
      if (mid < pos)
         tree_write(2 * id + 2, mid + 1, hi, pos, v);
      else
         tree_write(2 * id + 1, lo, mid, pos, v);
      node_put(id, combine(node_get(2 * id + 1), node_get(2 * id + 2)));
   endfunction

   function automatic pair_type tree_range(int unsigned id, int unsigned lo, int unsigned hi,
                                           int unsigned s, int unsigned e);
      int unsigned mid;
      if (s <= lo && hi <= e)
         return node_get(id);
      mid = (lo + hi) / 2;
      if (mid < s)
         return tree_range(2 * id + 2, mid + 1, hi, s, e);
      if (mid + 1 > e)
         return tree_range(2 * id + 1, lo, mid, s, e);
      return combine(tree_range(2 * id + 1, lo, mid, s, e),
                     tree_range(2 * id + 2, mid + 1, hi, s, e));
   endfunction

   function automatic answer_type tree_answer(op_type w);
      answer_type  a;
      pair_type    r;
      int unsigned pos;
      int unsigned s;
      int unsigned e;
      a = '{'0, '0, 1'b0, gst_pkg::STATUS_OK};
      pos = 32'(w.position);
      s = 32'(w.range_start);
      e = 32'(w.range_end);
      if (w.cmd == gst_pkg::CMD_UPDATE) begin
         if (pos >= element_count) begin
            a.status = gst_pkg::STATUS_ERROR;
            n_invalid++;
         end else begin
            tree_write(0, 0, element_count - 1, pos,
                       {32'd0, w.value & gst_pkg::VALUE_MASK});
            n_update++;
         end
      end else begin
         if (s > e || e >= element_count) begin
            a.status = gst_pkg::STATUS_ERROR;
            n_invalid++;
         end else begin
            r = tree_range(0, 0, element_count - 1, s, e);
            a.gcd = r.g[31:0];
            a.lcm = r.l;
            a.sat = r.sat;
            n_query++;
            if (r.sat)
               n_sat++;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else if (start && !busy) begin
         expected_answers.push_back(tree_answer(cur));
         start <= 1'b0;
         have_op = 0;
      end else if (csr_valid && csr_ready) begin
         element_count = (cur.count == '0) ? 1 :
                         (32'(cur.count) > gst_pkg::DEF_MAX_ELEMENTS) ?
                         gst_pkg::DEF_MAX_ELEMENTS : 32'(cur.count);
         n_csr++;
         csr_valid <= 1'b0;
         have_op = 0;
      end else if (start || csr_valid) begin
      end else if (!have_op) begin
         if (pending_ops.size() != 0) begin
            cur = pending_ops.pop_front();
            have_op = 1;
            hold_cnt = cur.gap;
         end
      end else if (cur.kind == OP_DRAIN) begin
         if (expected_answers.size() == 0 && !busy)
            have_op = 0;
      end else if (cur.kind == OP_CSR) begin
         if (expected_answers.size() == 0 && !busy) begin
            if (hold_cnt != 0) begin
               hold_cnt--;
            end else begin
               csr_element_count <= cur.count;
               csr_valid <= 1'b1;
            end
         end
      end else if (hold_cnt != 0) begin
         hold_cnt--;
      end else begin
         req_cmd <= cur.cmd;
         req_position <= cur.position;
         req_value <= cur.value;
         req_range_start <= cur.range_start;
         req_range_end <= cur.range_end;
         start <= 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type x;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: response with nothing expected", $time);
            errors++;
         end else begin
            x = expected_answers.pop_front();
            if (rsp_range_gcd !== x.gcd) begin
               $display("%0t: gcd exp %h got %h", $time, x.gcd, rsp_range_gcd);
               errors++;
            end
            if (rsp_range_lcm !== x.lcm) begin
               $display("%0t: lcm exp %h got %h", $time, x.lcm, rsp_range_lcm);
               errors++;
            end
            if (rsp_lcm_saturated !== x.sat) begin
               $display("%0t: sat exp %b got %b", $time, x.sat, rsp_lcm_saturated);
               errors++;
            end
            if (rsp_status !== x.status) begin
               $display("%0t: status exp %b got %b", $time, x.status, rsp_status);
               errors++;
            end
         end
      end
   end

   bit burst = 0;

   function automatic int unsigned pick_gap();
      if ($urandom_range(15) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(8);
   endfunction

   function automatic void push_word(gst_pkg::cmd_type c, int unsigned pos, logic [31:0] v,
                                     int unsigned s, int unsigned e);
      op_type o;
      o.kind = OP_WORD;
      o.cmd = c;
      o.position = gst_pkg::REQ_IDX_W'(pos);
      o.value = v;
      o.range_start = gst_pkg::REQ_IDX_W'(s);
      o.range_end = gst_pkg::REQ_IDX_W'(e);
      o.count = '0;
      o.gap = pick_gap();
      pending_ops.push_back(o);
   endfunction

   function automatic void push_csr(logic [gst_pkg::CFG_W-1:0] n);
      op_type o;
      o = '{OP_CSR, gst_pkg::CMD_UPDATE, '0, '0, '0, '0, n, $urandom_range(8)};
      pending_ops.push_back(o);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return $urandom_range(1, 30);
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(1, 60) << $urandom_range(20);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [gst_pkg::CFG_W-1:0] counts[8];
      int unsigned n, lo, hi, s, e, cnt_v;

      counts = '{11'd5, 11'd1, 11'd2047, 11'd33, 11'd0, 11'd2, 11'd1024, 11'd100};

      push_word(gst_pkg::CMD_UPDATE, 0, 32'hFFFF_FFFF, 0, 0);
      push_word(gst_pkg::CMD_UPDATE, 1023, 32'hFFFF_FFFE, 0, 0);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 0, 1023);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 1023, 1023);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 0, 0);
      push_word(gst_pkg::CMD_UPDATE, 1, 12, 0, 0);
      push_word(gst_pkg::CMD_UPDATE, 2, 18, 0, 0);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 1, 2);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 0, 2);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 3, 2);
      push_word(gst_pkg::CMD_UPDATE, 4, 32'hFFFF_FFFB, 0, 0);
      push_word(gst_pkg::CMD_UPDATE, 5, 32'hFFFF_FFFF, 0, 0);
      push_word(gst_pkg::CMD_UPDATE, 6, 32'hFFFF_FFFE, 0, 0);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 4, 6);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 3, 6);
      push_word(gst_pkg::CMD_UPDATE, 3, 7, 0, 0);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 3, 6);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 0, 6);
      pending_ops.push_back('{OP_DRAIN, gst_pkg::CMD_UPDATE, '0, '0, '0, '0, '0, 0});
      push_csr(11'd7);
      push_word(gst_pkg::CMD_UPDATE, 7, 5, 0, 0);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 0, 7);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 2, 6);
      push_word(gst_pkg::CMD_QUERY, 0, 0, 0, 6);

      foreach (counts[k]) begin
         push_csr(counts[k]);
         cnt_v = 32'(counts[k]);
         n = (cnt_v == 0) ? 1 :
             (cnt_v > gst_pkg::DEF_MAX_ELEMENTS) ? gst_pkg::DEF_MAX_ELEMENTS : cnt_v;
         lo = $urandom_range(n - 1);
         hi = (lo + 11 < n) ? lo + 11 : n - 1;
         for (int i = 0; i < 19; i++) begin
            if ($urandom_range(9) == 0) begin
               push_word(gst_pkg::cmd_type'($urandom_range(1)), $urandom_range(1023),
                         $urandom, $urandom_range(1023), $urandom_range(1023));
            end else if ($urandom_range(9) < 4) begin
               push_word(gst_pkg::CMD_UPDATE, $urandom_range(lo, hi), pick_value(), 0, 0);
            end else if ($urandom_range(7) == 0) begin
               push_word(gst_pkg::CMD_QUERY, 0, 0, 0, n - 1);
            end else begin
               s = $urandom_range(lo, hi);
               e = $urandom_range(s, hi);
               push_word(gst_pkg::CMD_QUERY, $urandom_range(1023), $urandom, s, e);
            end
         end
         pending_ops.push_back('{OP_DRAIN, gst_pkg::CMD_UPDATE, '0, '0, '0, '0, '0, 0});
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_ops.size() != 0 || have_op || start || csr_valid ||
             expected_answers.size() != 0);
      repeat (200) @(posedge clock);
      $display("covered %0d queries (%0d saturated), %0d updates, %0d invalid words",
               n_query, n_sat, n_update, n_invalid);
      $display("over %0d element count settings including the clamped extremes", n_csr);
      if (errors == 0 && expected_answers.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
